/* sv/azc_pkg.sv */
// package with types, codes and defaults for the adc zone classifier latch
`default_nettype none

package azc_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int LIMIT_W         = 13;
    localparam int PERIOD_W        = 16;
    localparam int TIME_W          = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic [LIMIT_W-1:0] RANGE_TOP_RST = 13'h1000;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMERGENCY_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_TOP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 3'd5;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BUSY      = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_NOT_DUE   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ZONE_SAFE      = 2'd0,
        ZONE_WARNING   = 2'd1,
        ZONE_DANGER    = 2'd2,
        ZONE_EMERGENCY = 2'd3
    } t_zone;

    typedef struct packed {
        logic                enable;
        logic [LIMIT_W-1:0]  safe_limit;
        logic [LIMIT_W-1:0]  warning_limit;
        logic [LIMIT_W-1:0]  emergency_start;
        logic [LIMIT_W-1:0]  range_top;
        logic [PERIOD_W-1:0] sample_period;
    } t_cfg;

endpackage

`default_nettype wire

/* sv/azc_in_if.sv */
// input channel carrying one command or tick item
`default_nettype none

interface azc_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             cmd;
    logic [31:0]            now_time;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   sample_ok;

    modport source (output valid, cmd, now_time, sample_value, sample_ok, input ready);
    modport sink   (input valid, cmd, now_time, sample_value, sample_ok, output ready);
endinterface

`default_nettype wire

/* sv/azc_out_if.sv */
// output channel carrying one status and snapshot item
`default_nettype none

interface azc_out_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [2:0]             status;
    logic [1:0]             zone;
    logic [SAMPLE_BITS-1:0] level;
    logic                   sample_seen;
    logic                   sample_fault;
    logic                   latched;

    modport source (output valid, status, zone, level, sample_seen, sample_fault, latched,
                    input ready);
    modport sink   (input valid, status, zone, level, sample_seen, sample_fault, latched,
                    output ready);
endinterface

`default_nettype wire

/* sv/adc_zone_classifier_latch_top.sv */
// top level of the adc zone classifier latch: input stage, evaluation, result register
// path: input stage register, then evaluation and state update, then result register
// throughput: one item per cycle unless output stalls; state updates in eval cycle
// reset: synchronous active-low; clears state, flags, config to defaults and both valids
`default_nettype none

module adc_zone_classifier_latch_top
    import azc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    azc_in_if.sink                     i_in_ch,
    azc_out_if.source                  o_out_ch
);

    t_cfg w_cfg;

    logic                   r_s1_vld;
    logic [1:0]             r_s1_cmd;
    logic [TIME_W-1:0]      r_s1_now;
    logic [SAMPLE_BITS-1:0] r_s1_raw;
    logic                   r_s1_ok;

    logic                   r_out_vld;
    t_status                r_out_status;
    t_zone                  r_out_zone;
    logic [SAMPLE_BITS-1:0] r_out_level;
    logic                   r_out_has;
    logic                   r_out_fault;
    logic                   r_out_latched;

    logic                   w_adv;
    logic                   w_in_rdy;
    logic                   w_go;
    t_status                w_status;
    t_zone                  w_zone;
    logic [SAMPLE_BITS-1:0] w_level;
    logic                   w_has;
    logic                   w_fault;
    logic                   w_latched;

    azc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    assign w_adv    = !r_out_vld || o_out_ch.ready;
    assign w_in_rdy = !r_s1_vld || w_adv;
    assign w_go     = r_s1_vld && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_in_rdy) begin
            r_s1_vld <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && w_in_rdy) begin
            r_s1_cmd <= i_in_ch.cmd;
            r_s1_now <= i_in_ch.now_time;
            r_s1_raw <= i_in_ch.sample_value;
            r_s1_ok  <= i_in_ch.sample_ok;
        end
    end

    azc_state #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_go          (w_go),
        .i_cmd         (r_s1_cmd),
        .i_now         (r_s1_now),
        .i_raw         (r_s1_raw),
        .i_ok          (r_s1_ok),
        .o_status      (w_status),
        .o_zone        (w_zone),
        .o_level       (w_level),
        .o_sample_seen (w_has),
        .o_fault       (w_fault),
        .o_latched     (w_latched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_status  <= w_status;
            r_out_zone    <= w_zone;
            r_out_level   <= w_level;
            r_out_has     <= w_has;
            r_out_fault   <= w_fault;
            r_out_latched <= w_latched;
        end
    end

    assign i_in_ch.ready         = w_in_rdy;
    assign o_out_ch.valid        = r_out_vld;
    assign o_out_ch.status       = r_out_status;
    assign o_out_ch.zone         = r_out_zone;
    assign o_out_ch.level        = r_out_level;
    assign o_out_ch.sample_seen  = r_out_has;
    assign o_out_ch.sample_fault = r_out_fault;
    assign o_out_ch.latched      = r_out_latched;

endmodule

`default_nettype wire

/* sv/azc_cfg_regs.sv */
// configuration register file written through the plain write port
`default_nettype none

module azc_cfg_regs
    import azc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable          <= 1'b0;
            r_cfg.safe_limit      <= '0;
            r_cfg.warning_limit   <= '0;
            r_cfg.emergency_start <= '0;
            r_cfg.range_top       <= RANGE_TOP_RST;
            r_cfg.sample_period   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:          r_cfg.enable          <= i_cfg_wdata[0];
                CFG_SAFE_LIMIT:      r_cfg.safe_limit      <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_WARNING_LIMIT:   r_cfg.warning_limit   <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_EMERGENCY_START: r_cfg.emergency_start <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_RANGE_TOP:       r_cfg.range_top       <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_SAMPLE_PERIOD:   r_cfg.sample_period   <= i_cfg_wdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* sv/azc_state.sv */
// sample qualifier state, clamp, zone classification and emergency latch
`default_nettype none

module azc_state
    import azc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_go,
    input  wire logic [1:0]             i_cmd,
    input  wire logic [TIME_W-1:0]      i_now,
    input  wire logic [SAMPLE_BITS-1:0] i_raw,
    input  wire logic                   i_ok,
    output t_status                     o_status,
    output t_zone                       o_zone,
    output logic [SAMPLE_BITS-1:0]      o_level,
    output logic                        o_sample_seen,
    output logic                        o_fault,
    output logic                        o_latched
);

    localparam int CW = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;

    logic [TIME_W-1:0]      r_last_time, n_last_time;
    logic [SAMPLE_BITS-1:0] r_level, n_level;
    t_zone                  r_zone, n_zone;
    logic                   r_sample_seen, n_sample_seen;
    logic                   r_fault, n_fault;
    logic                   r_latched, n_latched;

    logic [TIME_W-1:0]  w_delta;
    logic               w_due;
    logic [LIMIT_W-1:0] w_ceil;
    logic [CW-1:0]      w_raw_x;
    logic [CW-1:0]      w_ceil_x;
    logic [CW-1:0]      w_clamp;
    t_zone              w_class;
    t_status            w_status;

    assign w_delta  = i_now - r_last_time;
    assign w_due    = w_delta >= {{(TIME_W-PERIOD_W){1'b0}}, i_cfg.sample_period};
    assign w_ceil   = (i_cfg.range_top == '0) ? '0 : i_cfg.range_top - 13'd1;
    assign w_raw_x  = CW'(i_raw);
    assign w_ceil_x = CW'(w_ceil);
    assign w_clamp  = (w_raw_x > w_ceil_x) ? w_ceil_x : w_raw_x;

    always_comb begin
        if (w_clamp < CW'(i_cfg.safe_limit)) begin
            w_class = ZONE_SAFE;
        end else if (w_clamp < CW'(i_cfg.warning_limit)) begin
            w_class = ZONE_WARNING;
        end else if (w_clamp < CW'(i_cfg.emergency_start)) begin
            w_class = ZONE_DANGER;
        end else begin
            w_class = ZONE_EMERGENCY;
        end
    end

    always_comb begin
        n_last_time   = r_last_time;
        n_level       = r_level;
        n_zone        = r_zone;
        n_sample_seen = r_sample_seen;
        n_fault       = r_fault;
        n_latched     = r_latched;
        w_status      = ST_OK;
        if (!i_cfg.enable) begin
            w_status = ST_NOT_READY;
        end else begin
            case (i_cmd)
                CMD_TICK: begin
                    if (!w_due) begin
                        w_status = ST_NOT_DUE;
                    end else begin
                        n_last_time = i_now;
                        if (!i_ok) begin
                            n_fault = 1'b1;
                        end else begin
                            n_level       = w_clamp[SAMPLE_BITS-1:0];
                            n_zone        = w_class;
                            n_sample_seen = 1'b1;
                            n_fault       = 1'b0;
                            if (w_class == ZONE_EMERGENCY) begin
                                n_latched = 1'b1;
                            end
                        end
                    end
                end
                CMD_CLEAR: begin
                    if (!r_sample_seen) begin
                        w_status = ST_EMPTY;
                    end else if (r_zone == ZONE_EMERGENCY) begin
                        w_status = ST_BUSY;
                    end else begin
                        n_latched = 1'b0;
                    end
                end
                default: begin
                    w_status = r_sample_seen ? ST_OK : ST_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time   <= '0;
            r_level       <= '0;
            r_zone        <= ZONE_SAFE;
            r_sample_seen <= 1'b0;
            r_fault       <= 1'b0;
            r_latched     <= 1'b0;
        end else if (i_go) begin
            r_last_time   <= n_last_time;
            r_level       <= n_level;
            r_zone        <= n_zone;
            r_sample_seen <= n_sample_seen;
            r_fault       <= n_fault;
            r_latched     <= n_latched;
        end
    end

    assign o_status      = w_status;
    assign o_zone        = n_zone;
    assign o_level       = n_level;
    assign o_sample_seen = n_sample_seen;
    assign o_fault       = n_fault;
    assign o_latched     = n_latched;

    // latch sets only on an emergency sample
    a_latch_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_latched) |-> r_zone == ZONE_EMERGENCY)
        else $error("latch set without emergency zone");

    // latch drops only by a clear with a non-emergency sample
    a_latch_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_latched) |-> r_sample_seen && r_zone != ZONE_EMERGENCY
            && $past(i_cmd) == CMD_CLEAR)
        else $error("latch dropped illegally");

    // no level or zone without a good sample
    a_empty_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sample_seen |-> r_level == '0 && r_zone == ZONE_SAFE && !r_latched)
        else $error("snapshot changed without a good sample");

    // state moves only on a transfer into the evaluation stage
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_go) && $past(i_rst_n) |-> $stable(r_last_time) && $stable(r_latched))
        else $error("state changed without an item");

endmodule

`default_nettype wire

/* bench/tb.sv */
// self-checking bench for the adc zone classifier latch: random bursts, stalls, config phases
module tb;
    import azc_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [1:0]                 cmd;
        logic [TIME_W-1:0]          now_time;
        logic [SAMPLE_BITS_DEF-1:0] sample_value;
        logic                       sample_ok;
    } tick_item_t;

    typedef struct {
        t_status                    status;
        t_zone                      zone;
        logic [SAMPLE_BITS_DEF-1:0] level;
        logic                       sample_seen;
        logic                       sample_fault;
        logic                       latched;
    } snapshot_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    azc_in_if  #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_ch ();
    azc_out_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) out_ch ();

    adc_zone_classifier_latch_top #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    // shadow of the classifier: configuration and state
    t_cfg                       shadow_cfg = '{enable: 1'b0, safe_limit: '0, warning_limit: '0,
                                               emergency_start: '0, range_top: RANGE_TOP_RST,
                                               sample_period: '0};
    logic [TIME_W-1:0]          last_ms    = '0;
    logic [SAMPLE_BITS_DEF-1:0] held_level = '0;
    t_zone                      held_zone  = ZONE_SAFE;
    logic                       has_level  = 1'b0;
    logic                       fault_seen = 1'b0;
    logic                       alarm_latch = 1'b0;

    tick_item_t pending_items[$];
    snapshot_t  snapshot_q[$];
    int unsigned drv_count = 0;
    int unsigned acc_count = 0;
    int unsigned err_count = 0;

    tick_item_t  drv_item;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    int unsigned hold_left = 0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;
    int unsigned rx_mode = 0;
    int unsigned rx_cnt = 0;
    int unsigned rx_tick = 0;

    snapshot_t   oldest;
    logic [TIME_W-1:0] clock_ms = '0;

    function automatic t_zone zone_of(input logic [SAMPLE_BITS_DEF-1:0] v);
        logic [LIMIT_W-1:0] w;
        w = {1'b0, v};
        if (w < shadow_cfg.safe_limit) return ZONE_SAFE;
        if (w < shadow_cfg.warning_limit) return ZONE_WARNING;
        if (w < shadow_cfg.emergency_start) return ZONE_DANGER;
        return ZONE_EMERGENCY;
    endfunction

    function automatic snapshot_t advance_classifier(input tick_item_t it);
        snapshot_t          r;
        logic [LIMIT_W-1:0] ceiling;
        logic [SAMPLE_BITS_DEF-1:0] v;
        r.status = ST_OK;
        if (!shadow_cfg.enable) begin
            r.status = ST_NOT_READY;
        end else if (it.cmd == CMD_TICK) begin
            if ((it.now_time - last_ms) < {16'd0, shadow_cfg.sample_period}) begin
                r.status = ST_NOT_DUE;
            end else begin
                last_ms = it.now_time;
                if (!it.sample_ok) begin
                    fault_seen = 1'b1;
                end else begin
                    ceiling = (shadow_cfg.range_top != '0) ? shadow_cfg.range_top - 1'b1 : '0;
                    v = it.sample_value;
                    if ({1'b0, v} > ceiling) v = ceiling[SAMPLE_BITS_DEF-1:0];
                    held_level = v;
                    held_zone  = zone_of(v);
                    has_level  = 1'b1;
                    fault_seen = 1'b0;
                    if (held_zone == ZONE_EMERGENCY) alarm_latch = 1'b1;
                end
            end
        end else if (it.cmd == CMD_CLEAR) begin
            if (!has_level) r.status = ST_EMPTY;
            else if (held_zone == ZONE_EMERGENCY) r.status = ST_BUSY;
            else alarm_latch = 1'b0;
        end else begin
            r.status = has_level ? ST_OK : ST_EMPTY;
        end
        r.zone         = held_zone;
        r.level        = held_level;
        r.sample_seen  = has_level;
        r.sample_fault = fault_seen;
        r.latched      = alarm_latch;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // transfer monitor, config shadow and result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_ENABLE:          shadow_cfg.enable          = cfg_wdata[0];
                    CFG_SAFE_LIMIT:      shadow_cfg.safe_limit      = cfg_wdata[LIMIT_W-1:0];
                    CFG_WARNING_LIMIT:   shadow_cfg.warning_limit   = cfg_wdata[LIMIT_W-1:0];
                    CFG_EMERGENCY_START: shadow_cfg.emergency_start = cfg_wdata[LIMIT_W-1:0];
                    CFG_RANGE_TOP:       shadow_cfg.range_top       = cfg_wdata[LIMIT_W-1:0];
                    CFG_SAMPLE_PERIOD:   shadow_cfg.sample_period   = cfg_wdata[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                snapshot_q.push_back(advance_classifier('{in_ch.cmd, in_ch.now_time,
                                                          in_ch.sample_value, in_ch.sample_ok}));
                acc_count++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (snapshot_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("unexpected result: status %0d zone %0d level %0d", out_ch.status,
                                 out_ch.zone, out_ch.level);
                    end
                end else begin
                    oldest = snapshot_q.pop_front();
                    if (out_ch.status !== oldest.status || out_ch.zone !== oldest.zone ||
                        out_ch.level !== oldest.level ||
                        out_ch.sample_seen !== oldest.sample_seen ||
                        out_ch.sample_fault !== oldest.sample_fault ||
                        out_ch.latched !== oldest.latched) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("mismatch: exp st %0d zn %0d lv %0d hs %0b ft %0b la %0b",
                                     oldest.status, oldest.zone, oldest.level, oldest.sample_seen,
                                     oldest.sample_fault, oldest.latched);
                            $display("          got st %0d zn %0d lv %0d hs %0b ft %0b la %0b",
                                     out_ch.status, out_ch.zone, out_ch.level, out_ch.sample_seen,
                                     out_ch.sample_fault, out_ch.latched);
                        end
                    end
                end
            end
        end
    end

    // sender: bursts of items with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && acc_count != drv_count) begin
        end else if (gap_left > 0) begin
            gap_left--;
            in_ch.valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
            in_ch.valid <= 1'b0;
        end else begin
            drv_item = pending_items.pop_front();
            drv_count++;
            in_ch.cmd          <= drv_item.cmd;
            in_ch.now_time     <= drv_item.now_time;
            in_ch.sample_value <= drv_item.sample_value;
            in_ch.sample_ok    <= drv_item.sample_ok;
            in_ch.valid        <= 1'b1;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
    end

    // receiver: stall patterns that change at random intervals, one long hold-off
    always @(negedge i_clk) begin
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = 300;
            out_ch.ready <= 1'b0;
        end else begin
            if (rx_cnt == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_cnt = $urandom_range(16, 96);
            end
            rx_cnt--;
            case (rx_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= $urandom_range(0, 1);
                2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= rx_tick[2];
            endcase
        end
    end

    task automatic offer(input logic [1:0] c, input logic [TIME_W-1:0] t,
                         input logic [SAMPLE_BITS_DEF-1:0] v, input logic ok);
        pending_items.push_back('{c, t, v, ok});
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || acc_count != drv_count || snapshot_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic new_phase(input int unsigned en, input int unsigned s, input int unsigned w,
                             input int unsigned e, input int unsigned r, input int unsigned p);
        drain();
        repeat (4) @(negedge i_clk);
        write_reg(CFG_ENABLE, en);
        write_reg(CFG_SAFE_LIMIT, s);
        write_reg(CFG_WARNING_LIMIT, w);
        write_reg(CFG_EMERGENCY_START, e);
        write_reg(CFG_RANGE_TOP, r);
        write_reg(CFG_SAMPLE_PERIOD, p);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic offer_random();
        int unsigned pick;
        int          sv;
        int          thr;
        logic [1:0]  c;
        logic [TIME_W-1:0] t;
        pick = $urandom_range(0, 99);
        if (pick < 70) c = CMD_TICK;
        else if (pick < 85) c = CMD_CLEAR;
        else if (pick < 97) c = CMD_READ;
        else c = CMD_SPARE;
        pick = $urandom_range(0, 19);
        if (pick == 0) clock_ms = $urandom;
        else if (pick == 1)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * shadow_cfg.sample_period + 2);
        else clock_ms = clock_ms + $urandom_range(0, 2 * shadow_cfg.sample_period + 2);
        t = (c == CMD_TICK) ? clock_ms : $urandom;
        pick = $urandom_range(0, 9);
        case (pick)
            0: sv = 0;
            1: sv = 4095;
            2, 3, 4: begin
                case ($urandom_range(0, 3))
                    0:       thr = shadow_cfg.safe_limit;
                    1:       thr = shadow_cfg.warning_limit;
                    2:       thr = shadow_cfg.emergency_start;
                    default: thr = shadow_cfg.range_top;
                endcase
                sv = thr + int'($urandom_range(0, 6)) - 3;
                if (sv < 0) sv = 0;
                if (sv > 4095) sv = 4095;
            end
            default: sv = $urandom_range(0, 4095);
        endcase
        offer(c, t, sv[SAMPLE_BITS_DEF-1:0], $urandom_range(0, 7) != 0);
    endtask

    task automatic random_phase();
        int unsigned en;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned x;
        int unsigned r;
        int unsigned p;
        en = ($urandom_range(0, 9) == 0) ? 0 : 1;
        a = $urandom_range(0, 4096);
        b = $urandom_range(0, 4096);
        c = $urandom_range(0, 4096);
        case ($urandom_range(0, 5))
            3: begin
                a = ($urandom_range(0, 1) == 0) ? 0 : 4096;
                b = ($urandom_range(0, 1) == 0) ? 0 : 4096;
                c = ($urandom_range(0, 1) == 0) ? a : 4096;
            end
            4: ;
            default: begin
                if (a > b) begin x = a; a = b; b = x; end
                if (b > c) begin x = b; b = c; c = x; end
                if (a > b) begin x = a; a = b; b = x; end
            end
        endcase
        case ($urandom_range(0, 7))
            0, 1:    r = 4096;
            2:       r = 0;
            3:       r = 1;
            default: r = $urandom_range(0, 4096);
        endcase
        case ($urandom_range(0, 7))
            0:       p = 0;
            1:       p = 65535;
            default: p = $urandom_range(1, 40);
        endcase
        new_phase(en, a, b, c, r, p);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.cmd          = CMD_TICK;
        in_ch.now_time     = '0;
        in_ch.sample_value = '0;
        in_ch.sample_ok    = 1'b0;
        out_ch.ready       = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // disabled block
        new_phase(0, 1000, 2000, 3000, 4096, 0);
        offer(CMD_TICK, 32'd10, 12'd3500, 1'b1);
        offer(CMD_CLEAR, 32'd11, 12'd0, 1'b0);

        // basic zones, latch, clear rules, failed sample
        new_phase(1, 1000, 2000, 3000, 4096, 0);
        offer(CMD_READ, 32'd0, 12'd0, 1'b1);
        offer(CMD_CLEAR, 32'd0, 12'd0, 1'b1);
        offer(CMD_TICK, 32'h0000_0100, 12'd0, 1'b1);
        offer(CMD_TICK, 32'h8000_0000, 12'd1500, 1'b1);
        offer(CMD_TICK, 32'h8000_0001, 12'd2500, 1'b1);
        offer(CMD_TICK, 32'hFFFF_FFFF, 12'd4095, 1'b1);
        offer(CMD_CLEAR, 32'd0, 12'd0, 1'b1);
        offer(CMD_TICK, 32'h1234_5678, 12'd999, 1'b0);
        offer(CMD_TICK, 32'hFFFF_FF00, 12'd500, 1'b1);
        offer(CMD_SPARE, 32'hFFFF_FFFF, 12'hFFF, 1'b1);
        offer(CMD_TICK, 32'hFFFF_FFC0, 12'd10, 1'b1);
        offer(CMD_CLEAR, 32'd0, 12'd0, 1'b1);

        // period with time wrap
        new_phase(1, 1000, 2000, 3000, 4096, 100);
        offer(CMD_TICK, 32'hFFFF_FFFF, 12'd1200, 1'b1);
        offer(CMD_TICK, 32'h0000_0024, 12'd1300, 1'b1);
        offer(CMD_TICK, 32'h0000_0087, 12'd1400, 1'b1);

        // zero range clamps to zero
        new_phase(1, 1, 2, 3, 0, 0);
        offer(CMD_TICK, 32'd5, 12'd4095, 1'b1);

        // widest limits and period
        new_phase(1, 4096, 4096, 4096, 4096, 65535);
        offer(CMD_TICK, 32'd5 + 32'd65535, 12'd4095, 1'b1);
        offer(CMD_TICK, 32'd5 + 32'd65535 + 32'd65534, 12'd4095, 1'b1);

        // zero limits make everything emergency
        new_phase(1, 0, 0, 0, 1, 0);
        offer(CMD_TICK, 32'd77, 12'd2222, 1'b1);
        offer(CMD_CLEAR, 32'd78, 12'd0, 1'b1);

        for (int ph = 0; ph < 9; ph++) begin
            random_phase();
            if (ph == 2) long_hold_req = 1'b1;
            for (int k = 0; k < 105; k++) offer_random();
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (err_count == 0 && snapshot_q.size() == 0) $display("tb passed");
        else $display("tb failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("tb failed");
        $finish;
    end

endmodule
